>>> rtl/tcp_tx_window_state_table_unit_assert.svh
// ----------------------------------------------------------------------------
// TCP TX window state table - assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TCP_TX_WINDOW_STATE_TABLE_UNIT_ASSERT_SVH
`define TCP_TX_WINDOW_STATE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define TCPTX_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication, quiet during reset
`define TCPTX_ASSERT_DLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define TCPTX_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcptx_pkg.sv
// ----------------------------------------------------------------------------
// TCP TX window state table - package
// Widths, codes and payload/entry types shared by the RTL and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcptx_pkg;

  // table geometry
  localparam int SESSIONS  = 1024;
  localparam int SESSION_W = 10;
  localparam int ADDR_W    = $clog2(SESSIONS);

  // field widths
  localparam int SEQ_W   = 32;
  localparam int WIN_W   = 30;
  localparam int RWIN_W  = 16;
  localparam int SHIFT_W = 4;
  localparam int DUP_W   = 2;
  localparam int FLAG_W  = 3;
  localparam int CFG_IDX_W = 2;

  // flag bits in an entry
  localparam int FLAG_RDY = 0;
  localparam int FLAG_SNT = 1;
  localparam int FLAG_FRX = 2;

  // register reset values
  localparam logic [WIN_W-1:0] INIT_CWND_RST = WIN_W'(32'h3908);
  localparam logic [WIN_W-1:0] INIT_THR_RST  = WIN_W'(32'hFFFF);

  typedef enum logic [2:0] {
    OP_TX_READ  = 3'd0,
    OP_TX_WRITE = 3'd1,
    OP_RETX     = 3'd2,
    OP_APP_PUSH = 3'd3,
    OP_RX_WRITE = 3'd4,
    OP_RX_READ  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TX_REPLY = 2'd0,
    KIND_RX_REPLY = 2'd1,
    KIND_ACK_PUSH = 2'd2,
    KIND_INIT_ACK = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_EN   = 2'd0,
    CFG_NODELAY_EN = 2'd1,
    CFG_INIT_CWND  = 2'd2,
    CFG_INIT_THR   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [SESSION_W-1:0] session;
    logic [SEQ_W-1:0]     sequence_req;
    logic [WIN_W-1:0]     window_value;
    logic                 init_flag;
    logic                 fin_ready_in;
    logic                 fin_sent_in;
    logic [RWIN_W-1:0]    recv_window_in;
    logic [DUP_W-1:0]     dup_count_in;
    logic                 fast_retx_in;
    logic [SHIFT_W-1:0]   win_shift_in;
  } req_t;

  typedef struct packed {
    kind_t                kind;
    logic [SESSION_W-1:0] out_session;
    logic [SEQ_W-1:0]     acked_out;
    logic [SEQ_W-1:0]     unacked_out;
    logic [WIN_W-1:0]     window_out;
    logic [SEQ_W-1:0]     app_out;
    logic [WIN_W-1:0]     used_length;
    logic [WIN_W-1:0]     threshold_out;
    logic                 fin_ready_out;
    logic                 fin_sent_out;
    logic [DUP_W-1:0]     dup_count_out;
    logic                 fast_retx_out;
  } result_t;

  // one table entry
  typedef struct packed {
    logic [SEQ_W-1:0]   acked;
    logic [SEQ_W-1:0]   unacked;
    logic [SEQ_W-1:0]   app;
    logic [WIN_W-1:0]   cong;
    logic [WIN_W-1:0]   threshold;
    logic [RWIN_W-1:0]  peer_wnd;
    logic [SHIFT_W-1:0] shift;
    logic [DUP_W-1:0]   dup;
    logic [FLAG_W-1:0]  flags;
  } entry_t;

  // configuration register set
  typedef struct packed {
    logic             scale_en;
    logic             nodelay_en;
    logic [WIN_W-1:0] init_cwnd;
    logic [WIN_W-1:0] init_thr;
  } cfg_t;

  // update and result produced for one request
  typedef struct packed {
    logic    wr_en;
    entry_t  wr_entry;
    logic    res_valid;
    result_t res;
  } calc_out_t;

endpackage

`default_nettype wire

>>> rtl/tcptx_calc.sv
// ----------------------------------------------------------------------------
// TCP TX window state table - request evaluation
// Combinational update of one table entry and the result for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module tcptx_calc
  import tcptx_pkg::*;
(
  input  req_t      req,
  input  entry_t    entry,
  input  cfg_t      cfg,
  output calc_out_t calc
);

  // smaller of congestion window and (optionally scaled) receive window
  function automatic logic [WIN_W-1:0] min_win(
    input logic [WIN_W-1:0]   cong,
    input logic [RWIN_W-1:0]  rwin,
    input logic [SHIFT_W-1:0] sh,
    input logic               scale
  );
    logic [WIN_W-1:0] scaled;
    scaled = WIN_W'(rwin);
    if (scale) begin
      scaled = scaled << sh;
    end
    return (cong < scaled) ? cong : scaled;
  endfunction

  logic [WIN_W-1:0]   used_len;
  logic [WIN_W-1:0]   tx_min;
  logic [WIN_W-1:0]   usable;
  logic [SHIFT_W-1:0] rx_shift;
  logic [SEQ_W-1:0]   seq_diff;

  // transmit-read window math
  assign seq_diff = entry.unacked - entry.acked;
  assign used_len = seq_diff[WIN_W-1:0];
  assign tx_min   = min_win(entry.cong, entry.peer_wnd, entry.shift, cfg.scale_en);
  assign usable   = (tx_min > used_len) ? (tx_min - used_len) : '0;
  assign rx_shift = req.init_flag ? req.win_shift_in : entry.shift;

  // per-opcode update and result
  always_comb begin
    calc                 = '0;
    calc.wr_entry        = entry;
    calc.res.out_session = req.session;
    case (req.opcode)
      OP_TX_READ: begin
        calc.res_valid         = 1'b1;
        calc.res.kind          = KIND_TX_REPLY;
        calc.res.acked_out     = entry.acked;
        calc.res.unacked_out   = entry.unacked;
        calc.res.window_out    = usable;
        calc.res.app_out       = entry.app;
        calc.res.used_length   = used_len;
        calc.res.fin_ready_out = entry.flags[FLAG_RDY];
        calc.res.fin_sent_out  = entry.flags[FLAG_SNT];
      end
      OP_TX_WRITE: begin
        calc.wr_en            = 1'b1;
        calc.wr_entry.unacked = req.sequence_req;
        if (req.init_flag) begin
          calc.wr_entry.app       = req.sequence_req;
          calc.wr_entry.acked     = req.sequence_req - SEQ_W'(1);
          calc.wr_entry.cong      = cfg.init_cwnd;
          calc.wr_entry.threshold = cfg.init_thr;
          calc.wr_entry.flags[FLAG_RDY] = req.fin_ready_in;
          calc.wr_entry.flags[FLAG_SNT] = req.fin_sent_in;
          calc.res_valid          = 1'b1;
          calc.res.kind           = KIND_INIT_ACK;
          calc.res.acked_out      = req.sequence_req;
          calc.res.window_out     = cfg.nodelay_en ? cfg.init_cwnd : '0;
        end else begin
          calc.wr_entry.flags[FLAG_RDY] = entry.flags[FLAG_RDY] | req.fin_ready_in;
          calc.wr_entry.flags[FLAG_SNT] = entry.flags[FLAG_SNT] | req.fin_sent_in;
        end
      end
      OP_RETX: begin
        calc.wr_en              = 1'b1;
        calc.wr_entry.threshold = req.window_value;
        calc.wr_entry.cong      = cfg.init_cwnd;
      end
      OP_APP_PUSH: begin
        calc.wr_en        = 1'b1;
        calc.wr_entry.app = req.sequence_req;
      end
      OP_RX_WRITE: begin
        calc.wr_en                    = 1'b1;
        calc.wr_entry.acked           = req.sequence_req;
        calc.wr_entry.peer_wnd        = req.recv_window_in;
        calc.wr_entry.cong            = req.window_value;
        calc.wr_entry.dup             = req.dup_count_in;
        calc.wr_entry.flags[FLAG_FRX] = req.fast_retx_in;
        calc.wr_entry.shift           = rx_shift;
        calc.res_valid                = 1'b1;
        calc.res.kind                 = KIND_ACK_PUSH;
        calc.res.acked_out            = req.sequence_req;
        calc.res.window_out           = cfg.nodelay_en ?
            min_win(req.window_value, req.recv_window_in, rx_shift, cfg.scale_en) : '0;
      end
      OP_RX_READ: begin
        calc.res_valid         = 1'b1;
        calc.res.kind          = KIND_RX_REPLY;
        calc.res.acked_out     = entry.acked;
        calc.res.unacked_out   = entry.unacked;
        calc.res.window_out    = entry.cong;
        calc.res.threshold_out = entry.threshold;
        calc.res.dup_count_out = entry.dup;
        calc.res.fast_retx_out = entry.flags[FLAG_FRX];
      end
      default: begin
        // undefined opcodes: no update, no result
        calc.wr_en     = 1'b0;
        calc.res_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tcp_tx_window_state_table_unit.sv
// ----------------------------------------------------------------------------
// TCP TX window state table unit
// Per-session send sequence and window table with one request per clock while not busy.
// ----------------------------------------------------------------------------
//  channel   ports                         transfer when
//  request   start, busy, in_item          start & !busy
//  result    out_valid, out_result         out_valid (one cycle, no stall)
//  config    cfg_valid, cfg_ready,         cfg_valid & cfg_ready
//            cfg_index, cfg_data
//
//  One request per clock unless busy; request and result stages are both registered.
//  Rate is set by the table memory: one read and one write port per cycle,
//  with the pending write forwarded to a read of the same session.
//  After reset busy stays high while a clearing pass zeroes all SESSIONS (1024)
//  entries, one entry per cycle; config writes are taken then.
//  The result side cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_tx_window_state_table_unit
  import tcptx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_data,
  output logic                 out_valid,
  output result_t              out_result
);

  // configuration registers
  cfg_t cfg_r;

  // clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_idx_r;

  // request stage
  logic   req_valid_r;
  req_t   req_r;
  entry_t rd_entry_r;

  // result stage
  logic    out_valid_r;
  result_t out_result_r;

  // table
  entry_t            mem [SESSIONS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  calc_out_t calc;
  logic      accept;

  assign accept    = start & ~busy;
  assign busy      = clearing_r;
  assign cfg_ready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_en   <= 1'b1;
      cfg_r.nodelay_en <= 1'b0;
      cfg_r.init_cwnd  <= INIT_CWND_RST;
      cfg_r.init_thr   <= INIT_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SCALE_EN:   cfg_r.scale_en   <= cfg_data[0];
        CFG_NODELAY_EN: cfg_r.nodelay_en <= cfg_data[0];
        CFG_INIT_CWND:  cfg_r.init_cwnd  <= cfg_data;
        CFG_INIT_THR:   cfg_r.init_thr   <= cfg_data;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + ADDR_W'(1);
      if (clr_idx_r == ADDR_W'(SESSIONS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
  end

  // evaluate the registered request against its entry
  tcptx_calc u_calc (
    .req   (req_r),
    .entry (rd_entry_r),
    .cfg   (cfg_r),
    .calc  (calc)
  );

  // table write: clearing pass or update from the request stage
  assign rd_addr   = in_item.session[ADDR_W-1:0];
  assign mem_we    = clearing_r | (req_valid_r & calc.wr_en);
  assign mem_waddr = clearing_r ? clr_idx_r : req_r.session[ADDR_W-1:0];
  assign mem_wdata = clearing_r ? '0 : calc.wr_entry;

  // table storage with write-to-read forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == rd_addr)) begin
      rd_entry_r <= mem_wdata;
    end else begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_valid_r & calc.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_r) begin
      out_result_r <= calc.res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcptx_checker.sv
// ----------------------------------------------------------------------------
// TCP TX window state table - port checker
// Port-level checks on reset, request-to-result timing and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_tx_window_state_table_unit_assert.svh"

module tcptx_checker
  import tcptx_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    start,
  input logic    busy,
  input req_t    in_item,
  input logic    out_valid,
  input result_t out_result
);

  // table clearing holds off requests right after reset
  `TCPTX_ASSERT_RST(a_busy_after_reset, !rst_n, busy, "busy low after reset")

  // every result comes from an earlier transferred request
  `TCPTX_ASSERT_IMP(a_result_has_request, out_valid, $past(start && !busy, 2), "orphan result")

  // an init ack push only follows an init transmit write
  `TCPTX_ASSERT_IMP(a_init_ack_source, out_valid && (out_result.kind == KIND_INIT_ACK), $past(in_item.opcode == OP_TX_WRITE && in_item.init_flag && start && !busy, 2), "init ack without init write")

  // reads always answer
  `TCPTX_ASSERT_DLY(a_read_answers, start && !busy && (in_item.opcode == OP_TX_READ || in_item.opcode == OP_RX_READ), out_valid, "read gave no reply")

  // undefined opcodes stay silent
  `TCPTX_ASSERT_DLY(a_bad_op_silent, start && !busy && in_item.opcode[2] && in_item.opcode[1], !out_valid, "undefined opcode produced a result")

endmodule

bind tcp_tx_window_state_table_unit tcptx_checker u_tcptx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_valid  (out_valid),
  .out_result (out_result)
);

`default_nettype wire
